// ===== rtl/biquad_notch_cascade_defines.svh =====
// Assertion shorthands for the cascade checker.
// Each expects clk_i and rst_ni in the scope of use.
`ifndef BIQUAD_NOTCH_CASCADE_DEFINES_SVH
`define BIQUAD_NOTCH_CASCADE_DEFINES_SVH

// Same-cycle implication.
`define BNC_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication.
`define BNC_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// ===== rtl/bnc_pkg.sv =====
package bnc_pkg;

  localparam int SECTIONS    = 16;
  localparam int SAMPLE_BITS = 16;
  localparam int COEF_BITS   = 24;
  localparam int WFRAC       = 8;
  localparam int CFRAC       = COEF_BITS - 2;
  localparam int DLY_BITS    = 32;
  localparam int NCOEF       = 5;
  localparam int SEC_W       = $clog2(SECTIONS);
  localparam int CNT_W       = $clog2(SECTIONS + 1);
  localparam int COEF_DEPTH  = SECTIONS * NCOEF;
  localparam int COEF_AW     = $clog2(COEF_DEPTH);
  localparam int PROD_W      = COEF_BITS + DLY_BITS;
  localparam int ACC_W       = PROD_W + 2;
  localparam int STEP_W      = 4;

  localparam logic [STEP_W-1:0] STEP_FIRST = STEP_W'(0);
  localparam logic [STEP_W-1:0] STEP_DONE  = STEP_W'(11);

  localparam logic signed [ACC_W-1:0] W_HALF = ACC_W'(1) <<< (CFRAC - 1);
  localparam logic signed [ACC_W-1:0] Y_HALF = ACC_W'(1) <<< (CFRAC + WFRAC - 1);
  localparam logic signed [ACC_W-1:0] W_MAX  = (ACC_W'(1) <<< (DLY_BITS - 1)) - ACC_W'(1);
  localparam logic signed [ACC_W-1:0] W_MIN  = -(ACC_W'(1) <<< (DLY_BITS - 1));
  localparam logic signed [ACC_W-1:0] S_MAX  = (ACC_W'(1) <<< (SAMPLE_BITS - 1)) - ACC_W'(1);
  localparam logic signed [ACC_W-1:0] S_MIN  = -(ACC_W'(1) <<< (SAMPLE_BITS - 1));

  typedef enum logic [1:0] {
    REQ_SAMPLE = 2'd0,
    REQ_COEF   = 2'd1,
    REQ_CLEAR  = 2'd2,
    REQ_NONE   = 2'd3
  } req_e;

  typedef enum logic [2:0] {
    CI_B0 = 3'd0,
    CI_B1 = 3'd1,
    CI_B2 = 3'd2,
    CI_A0 = 3'd3,
    CI_A1 = 3'd4
  } coef_idx_e;

  typedef enum logic [2:0] {
    ACC_HOLD,
    ACC_LOAD_X,
    ACC_LOAD_P,
    ACC_ADD_P,
    ACC_SUB_P
  } acc_op_e;

  typedef enum logic [1:0] {
    MB_W1,
    MB_W2,
    MB_W
  } mul_b_e;

  typedef enum logic [1:0] {
    SEQ_NEXT,
    SEQ_LOOP,
    SEQ_DONE
  } seq_op_e;

  typedef struct packed {
    logic      coef_rd;
    coef_idx_e coef_sel;
    logic      dly_rd;
    logic      dly_latch;
    logic      dly_wr;
    logic      mul_en;
    mul_b_e    mul_b;
    acc_op_e   acc_op;
    logic      w_fin;
    logic      y_fin;
    seq_op_e   seq_op;
  } ucw_t;

  function automatic ucw_t ucode_rom(logic [STEP_W-1:0] step);
    ucw_t cw;
    cw = '0;
    case (step)
      4'd0: begin
        cw.coef_rd = 1'b1; cw.coef_sel = CI_A0; cw.dly_rd = 1'b1; cw.acc_op = ACC_LOAD_X;
      end
      4'd1: begin
        cw.dly_latch = 1'b1;
      end
      4'd2: begin
        cw.mul_en = 1'b1; cw.mul_b = MB_W1; cw.coef_rd = 1'b1; cw.coef_sel = CI_A1;
      end
      4'd3: begin
        cw.acc_op = ACC_SUB_P; cw.mul_en = 1'b1; cw.mul_b = MB_W2;
        cw.coef_rd = 1'b1; cw.coef_sel = CI_B0;
      end
      4'd4: begin
        cw.acc_op = ACC_SUB_P;
      end
      4'd5: begin
        cw.w_fin = 1'b1;
      end
      4'd6: begin
        cw.mul_en = 1'b1; cw.mul_b = MB_W; cw.coef_rd = 1'b1; cw.coef_sel = CI_B1;
      end
      4'd7: begin
        cw.acc_op = ACC_LOAD_P; cw.mul_en = 1'b1; cw.mul_b = MB_W1;
        cw.coef_rd = 1'b1; cw.coef_sel = CI_B2;
      end
      4'd8: begin
        cw.acc_op = ACC_ADD_P; cw.mul_en = 1'b1; cw.mul_b = MB_W2;
      end
      4'd9: begin
        cw.acc_op = ACC_ADD_P; cw.dly_wr = 1'b1;
      end
      4'd10: begin
        cw.y_fin = 1'b1; cw.seq_op = SEQ_LOOP;
      end
      default: begin
        cw.seq_op = SEQ_DONE;
      end
    endcase
    return cw;
  endfunction

  function automatic logic [COEF_AW-1:0] coef_addr(logic [SEC_W-1:0] sec,
                                                   logic [2:0] idx);
    return COEF_AW'(32'(sec) * NCOEF + 32'(idx));
  endfunction

endpackage

// ===== rtl/bnc_ram.sv =====
module bnc_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/bnc_seq.sv =====
module bnc_seq (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start_i,
  input  logic [bnc_pkg::CNT_W-1:0] n_i,
  input  logic                      out_free_i,
  output bnc_pkg::ucw_t             cw_o,
  output logic [bnc_pkg::SEC_W-1:0] sec_o,
  output logic                      busy_o,
  output logic                      emit_o
);

  logic                       run_q, run_d;
  logic [bnc_pkg::STEP_W-1:0] step_q, step_d;
  logic [bnc_pkg::SEC_W-1:0]  sec_q, sec_d;
  bnc_pkg::ucw_t              cw;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      step_q <= bnc_pkg::STEP_FIRST;
      sec_q  <= '0;
    end else begin
      run_q  <= run_d;
      step_q <= step_d;
      sec_q  <= sec_d;
    end
  end

  always_comb begin
    cw = run_q ? bnc_pkg::ucode_rom(step_q) : '0;
  end

  always_comb begin
    run_d  = run_q;
    step_d = step_q;
    sec_d  = sec_q;
    emit_o = 1'b0;
    if (!run_q) begin
      if (start_i) begin
        run_d  = 1'b1;
        sec_d  = '0;
        step_d = (n_i == '0) ? bnc_pkg::STEP_DONE : bnc_pkg::STEP_FIRST;
      end
    end else begin
      case (cw.seq_op)
        bnc_pkg::SEQ_NEXT: step_d = step_q + bnc_pkg::STEP_W'(1);
        bnc_pkg::SEQ_LOOP: begin
          if (bnc_pkg::CNT_W'(sec_q) + bnc_pkg::CNT_W'(1) < n_i) begin
            sec_d  = sec_q + bnc_pkg::SEC_W'(1);
            step_d = bnc_pkg::STEP_FIRST;
          end else begin
            step_d = bnc_pkg::STEP_DONE;
          end
        end
        bnc_pkg::SEQ_DONE: begin
          if (out_free_i) begin
            emit_o = 1'b1;
            run_d  = 1'b0;
          end
        end
        default: ;
      endcase
    end
  end

  assign cw_o   = cw;
  assign sec_o  = sec_q;
  assign busy_o = run_q;

endmodule

// ===== rtl/bnc_datapath.sv =====
module bnc_datapath (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  start_i,
  input  logic signed [bnc_pkg::SAMPLE_BITS-1:0] sample_i,
  input  bnc_pkg::ucw_t                         cw_i,
  input  logic signed [bnc_pkg::COEF_BITS-1:0]  coef_i,
  input  logic [2*bnc_pkg::DLY_BITS-1:0]        dly_row_i,
  output logic [2*bnc_pkg::DLY_BITS-1:0]        dly_wdata_o,
  output logic signed [bnc_pkg::SAMPLE_BITS-1:0] x_o,
  output logic                                  clip_o
);

  localparam int AW = bnc_pkg::ACC_W;
  localparam int DW = bnc_pkg::DLY_BITS;
  localparam int SW = bnc_pkg::SAMPLE_BITS;

  logic signed [DW-1:0]                 w1_q, w2_q, w_q;
  logic signed [bnc_pkg::PROD_W-1:0]    p_q;
  logic signed [AW-1:0]                 acc_q, acc_d;
  logic signed [SW-1:0]                 x_q;
  logic                                 clip_q;
  logic signed [DW-1:0]                 mul_b;
  logic signed [AW-1:0]                 x_ext, p_ext, w_sh, y_sh;
  logic signed [DW-1:0]                 w_sat;
  logic signed [SW-1:0]                 y_sat;
  logic                                 w_clip, y_clip;

  always_comb begin
    case (cw_i.mul_b)
      bnc_pkg::MB_W1: mul_b = w1_q;
      bnc_pkg::MB_W2: mul_b = w2_q;
      bnc_pkg::MB_W:  mul_b = w_q;
      default:        mul_b = w_q;
    endcase
  end

  always_comb begin
    x_ext = AW'(x_q);
    p_ext = AW'(p_q);
    case (cw_i.acc_op)
      bnc_pkg::ACC_LOAD_X: acc_d = x_ext <<< (bnc_pkg::CFRAC + bnc_pkg::WFRAC);
      bnc_pkg::ACC_LOAD_P: acc_d = p_ext;
      bnc_pkg::ACC_ADD_P:  acc_d = acc_q + p_ext;
      bnc_pkg::ACC_SUB_P:  acc_d = acc_q - p_ext;
      default:             acc_d = acc_q;
    endcase
  end

  always_comb begin
    w_sh   = (acc_q + bnc_pkg::W_HALF) >>> bnc_pkg::CFRAC;
    w_clip = 1'b1;
    if (w_sh > bnc_pkg::W_MAX) begin
      w_sat = bnc_pkg::W_MAX[DW-1:0];
    end else if (w_sh < bnc_pkg::W_MIN) begin
      w_sat = bnc_pkg::W_MIN[DW-1:0];
    end else begin
      w_sat  = w_sh[DW-1:0];
      w_clip = 1'b0;
    end
  end

  always_comb begin
    y_sh   = (acc_q + bnc_pkg::Y_HALF) >>> (bnc_pkg::CFRAC + bnc_pkg::WFRAC);
    y_clip = 1'b1;
    if (y_sh > bnc_pkg::S_MAX) begin
      y_sat = bnc_pkg::S_MAX[SW-1:0];
    end else if (y_sh < bnc_pkg::S_MIN) begin
      y_sat = bnc_pkg::S_MIN[SW-1:0];
    end else begin
      y_sat  = y_sh[SW-1:0];
      y_clip = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clip_q <= 1'b0;
    end else if (start_i) begin
      clip_q <= 1'b0;
    end else if ((cw_i.w_fin && w_clip) || (cw_i.y_fin && y_clip)) begin
      clip_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      x_q <= sample_i;
    end else if (cw_i.y_fin) begin
      x_q <= y_sat;
    end
    if (cw_i.dly_latch) begin
      w1_q <= dly_row_i[DW-1:0];
      w2_q <= dly_row_i[2*DW-1:DW];
    end
    if (cw_i.w_fin) begin
      w_q <= w_sat;
    end
    if (cw_i.mul_en) begin
      p_q <= coef_i * mul_b;
    end
    acc_q <= acc_d;
  end

  assign dly_wdata_o = {w1_q, w_q};
  assign x_o         = x_q;
  assign clip_o      = clip_q;

endmodule

// ===== rtl/biquad_notch_cascade.sv =====
// A sample runs through the N active sections (at most 16) before its result is valid;
// with no active section it passes straight through. Coefficient and clear items do not
// make the block busy. No new item is taken while a sample is in the cascade, but one is
// taken while a result waits. The microprogram steps the shared multiplier through five
// products per section. Reset clears delay words (row valid bits) and the register.
module biquad_notch_cascade (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [4:0]  cfg_data_i,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // [15:0] sample_in, [19:16] section_index, [22:20] coef_index, [46:23] coef_value
  input  logic [47:0] s_axis_tdata,
  // [1:0] req_type
  input  logic [1:0]  s_axis_tuser,
  input  logic        s_axis_tlast,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // [15:0] sample_out
  output logic [15:0] m_axis_tdata,
  // [0] clipped
  output logic [0:0]  m_axis_tuser,
  output logic        m_axis_tlast
);

  localparam int SW = bnc_pkg::SAMPLE_BITS;
  localparam int DW = bnc_pkg::DLY_BITS;

  logic                      s_xfer, start, coef_we, busy, emit, out_free;
  bnc_pkg::req_e             req;
  logic [3:0]                sec_in;
  logic [2:0]                ci_in;
  logic [4:0]                active_q;
  logic [bnc_pkg::CNT_W-1:0] n_eff;
  logic                      fe_q;
  logic [bnc_pkg::SECTIONS-1:0] dly_vld_q;
  bnc_pkg::ucw_t             cw;
  logic [bnc_pkg::SEC_W-1:0] sec;
  logic [bnc_pkg::COEF_BITS-1:0] coef_rdata;
  logic [2*DW-1:0]           dly_rdata, dly_row, dly_wdata;
  logic signed [SW-1:0]      x;
  logic                      clip;
  logic                      m_valid_q;
  logic [SW-1:0]             m_data_q;
  logic                      m_clip_q, m_last_q;

  assign req     = bnc_pkg::req_e'(s_axis_tuser);
  assign sec_in  = s_axis_tdata[19:16];
  assign ci_in   = s_axis_tdata[22:20];
  assign s_xfer  = s_axis_tvalid && s_axis_tready;
  assign start   = s_xfer && (req == bnc_pkg::REQ_SAMPLE);
  assign coef_we = s_xfer && (req == bnc_pkg::REQ_COEF) && (32'(sec_in) < bnc_pkg::SECTIONS)
                   && (ci_in inside {[bnc_pkg::CI_B0:bnc_pkg::CI_A1]});
  assign s_axis_tready = !busy;
  assign cfg_ready_o   = 1'b1;
  assign out_free      = !m_valid_q || m_axis_tready;
  assign n_eff = (active_q > 5'(bnc_pkg::SECTIONS)) ? bnc_pkg::CNT_W'(bnc_pkg::SECTIONS)
                                                    : bnc_pkg::CNT_W'(active_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q <= '0;
    end else if (cfg_valid_i) begin
      active_q <= cfg_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start) begin
      fe_q <= s_axis_tlast;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dly_vld_q <= '0;
    end else if (s_xfer && (req == bnc_pkg::REQ_CLEAR)) begin
      dly_vld_q <= '0;
    end else if (cw.dly_wr) begin
      dly_vld_q[sec] <= 1'b1;
    end
  end

  assign dly_row = dly_vld_q[sec] ? dly_rdata : '0;

  bnc_seq u_seq (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (start),
    .n_i        (n_eff),
    .out_free_i (out_free),
    .cw_o       (cw),
    .sec_o      (sec),
    .busy_o     (busy),
    .emit_o     (emit)
  );

  bnc_ram #(
    .WIDTH (bnc_pkg::COEF_BITS),
    .DEPTH (bnc_pkg::COEF_DEPTH)
  ) u_coef_ram (
    .clk_i   (clk_i),
    .we_i    (coef_we),
    .waddr_i (bnc_pkg::coef_addr(sec_in[bnc_pkg::SEC_W-1:0], ci_in)),
    .wdata_i (s_axis_tdata[46:23]),
    .re_i    (cw.coef_rd),
    .raddr_i (bnc_pkg::coef_addr(sec, cw.coef_sel)),
    .rdata_o (coef_rdata)
  );

  bnc_ram #(
    .WIDTH (2 * DW),
    .DEPTH (bnc_pkg::SECTIONS)
  ) u_dly_ram (
    .clk_i   (clk_i),
    .we_i    (cw.dly_wr),
    .waddr_i (sec),
    .wdata_i (dly_wdata),
    .re_i    (cw.dly_rd),
    .raddr_i (sec),
    .rdata_o (dly_rdata)
  );

  bnc_datapath u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (start),
    .sample_i    (s_axis_tdata[SW-1:0]),
    .cw_i        (cw),
    .coef_i      (coef_rdata),
    .dly_row_i   (dly_row),
    .dly_wdata_o (dly_wdata),
    .x_o         (x),
    .clip_o      (clip)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_valid_q <= 1'b0;
    end else if (emit) begin
      m_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      m_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      m_data_q <= x;
      m_clip_q <= clip;
      m_last_q <= fe_q;
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_data_q;
  assign m_axis_tuser  = m_clip_q;
  assign m_axis_tlast  = m_last_q;

endmodule

// ===== rtl/bnc_checker.sv =====
`include "biquad_notch_cascade_defines.svh"

module bnc_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        cfg_valid_i,
  input logic        cfg_ready_o,
  input logic [4:0]  cfg_data_i,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic [47:0] s_axis_tdata,
  input logic [1:0]  s_axis_tuser,
  input logic        s_axis_tlast,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [15:0] m_axis_tdata,
  input logic [0:0]  m_axis_tuser,
  input logic        m_axis_tlast
);

  logic s_xfer;
  logic m_stall;

  assign s_xfer  = s_axis_tvalid && s_axis_tready;
  assign m_stall = m_axis_tvalid && !m_axis_tready;

  `BNC_ASSERT_NXT(a_out_hold, m_stall, m_axis_tvalid)
  `BNC_ASSERT_NXT(a_out_stable, m_stall, $stable(m_axis_tdata) && $stable(m_axis_tuser))
  `BNC_ASSERT_NXT(a_sample_busy, s_xfer && (s_axis_tuser == bnc_pkg::REQ_SAMPLE), !s_axis_tready)
  `BNC_ASSERT_NXT(a_no_result, s_xfer && (s_axis_tuser != bnc_pkg::REQ_SAMPLE), !$rose(m_axis_tvalid))
  `BNC_ASSERT_NOW(a_cfg_ready, cfg_valid_i, cfg_ready_o)

endmodule

bind biquad_notch_cascade bnc_checker u_bnc_checker (.*);

// ===== tb/sv/tb_biquad_notch_cascade.sv =====
`timescale 1ns / 1ps

module tb_biquad_notch_cascade;
  import bnc_pkg::*;

  localparam int CYCLE_LIMIT  = 1_000_000;
  localparam int DRAIN_CYCLES = 11 * SECTIONS + 16;
  localparam int RAND_PER_SET = 93;

  typedef struct packed {
    req_e                          kind;
    logic signed [SAMPLE_BITS-1:0] smp;
    logic [SEC_W-1:0]              sec;
    logic [2:0]                    ci;
    logic signed [COEF_BITS-1:0]   cv;
    logic                          fe;
  } req_t;

  typedef struct packed {
    logic signed [SAMPLE_BITS-1:0] y;
    logic                          clip;
    logic                          fe;
  } out_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic [4:0]  cfg_data_i = '0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [47:0] s_axis_tdata = '0;
  logic [1:0]  s_axis_tuser = '0;
  logic        s_axis_tlast = 1'b0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [15:0] m_axis_tdata;
  logic [0:0]  m_axis_tuser;
  logic        m_axis_tlast;

  biquad_notch_cascade uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  // filter state mirror
  longint     coef_mem [0:SECTIONS*NCOEF-1];
  longint     delay_w1 [0:SECTIONS-1];
  longint     delay_w2 [0:SECTIONS-1];
  logic [4:0] n_sections = '0;

  req_t   pending_reqs[$];
  out_t   filtered_q[$];
  req_t   cur_req;
  out_t   got_out;
  out_t   want_out;
  bit     src_busy = 1'b0;
  int     src_wait = 0;
  int     src_quiet = 0;
  int     snk_wait = 0;
  int     snk_quiet = 0;
  int     mismatches = 0;
  int     cycles = 0;

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  function automatic int draw_wait(inout int quiet);
    if (quiet > 0) begin
      quiet--;
      return 0;
    end
    if ($urandom_range(0, 24) == 0) begin
      quiet = $urandom_range(8, 40);
      return 0;
    end
    return $urandom_range(0, 5);
  endfunction

  function automatic void run_cascade(input req_t r);
    longint x, acc, w, w1, w2;
    int     n, base;
    bit     clip;
    out_t   o;
    case (r.kind)
      REQ_COEF: begin
        if (r.ci < NCOEF) coef_mem[int'(r.sec) * NCOEF + int'(r.ci)] = r.cv;
      end
      REQ_CLEAR: begin
        for (int s = 0; s < SECTIONS; s++) begin
          delay_w1[s] = 0;
          delay_w2[s] = 0;
        end
      end
      REQ_SAMPLE: begin
        x = r.smp;
        clip = 1'b0;
        n = (n_sections > SECTIONS) ? SECTIONS : int'(n_sections);
        for (int s = 0; s < n; s++) begin
          base = s * NCOEF;
          w1 = delay_w1[s];
          w2 = delay_w2[s];
          acc = (x <<< (CFRAC + WFRAC)) - coef_mem[base + CI_A0] * w1
                - coef_mem[base + CI_A1] * w2;
          w = (acc + (longint'(1) <<< (CFRAC - 1))) >>> CFRAC;
          if (w > W_MAX) begin
            w = W_MAX;
            clip = 1'b1;
          end else if (w < W_MIN) begin
            w = W_MIN;
            clip = 1'b1;
          end
          acc = coef_mem[base + CI_B0] * w + coef_mem[base + CI_B1] * w1
                + coef_mem[base + CI_B2] * w2;
          x = (acc + (longint'(1) <<< (CFRAC + WFRAC - 1))) >>> (CFRAC + WFRAC);
          if (x > S_MAX) begin
            x = S_MAX;
            clip = 1'b1;
          end else if (x < S_MIN) begin
            x = S_MIN;
            clip = 1'b1;
          end
          delay_w2[s] = w1;
          delay_w1[s] = w;
        end
        o.y = SAMPLE_BITS'(x);
        o.clip = clip;
        o.fe = r.fe;
        filtered_q.push_back(o);
      end
      default: ;
    endcase
  endfunction

  function automatic req_t random_req(input req_e k);
    req_t r;
    r.kind = k;
    r.smp = SAMPLE_BITS'($urandom);
    r.sec = SEC_W'($urandom);
    r.ci = 3'($urandom);
    r.cv = COEF_BITS'($urandom);
    r.fe = ($urandom_range(0, 7) == 0);
    return r;
  endfunction

  // poles inside the unit circle: |a0| < 0.9, 0.1 <= a1 <= 0.9
  function automatic logic signed [COEF_BITS-1:0] stable_coef(input logic [2:0] ci);
    int v;
    case (ci)
      CI_A0:   v = int'($urandom_range(0, 7549746)) - 3774873;
      CI_A1:   v = int'($urandom_range(419430, 3774873));
      default: v = int'($urandom_range(0, 8388608)) - 4194304;
    endcase
    return COEF_BITS'(v);
  endfunction

  function automatic req_t coef_req(input int sec, input int ci, input int value);
    req_t r;
    r = random_req(REQ_COEF);
    r.sec = SEC_W'(sec);
    r.ci = 3'(ci);
    r.cv = COEF_BITS'(value);
    return r;
  endfunction

  function automatic req_t sample_req(input int value, input logic fe);
    req_t r;
    r = random_req(REQ_SAMPLE);
    r.smp = SAMPLE_BITS'(value);
    r.fe = fe;
    return r;
  endfunction

  function automatic req_t random_traffic();
    req_t r;
    int   pick;
    pick = $urandom_range(0, 199);
    if (pick < 160) begin
      r = random_req(REQ_SAMPLE);
      if ($urandom_range(0, 3) != 0)
        r.smp = SAMPLE_BITS'(int'($urandom_range(0, 4000)) - 2000);
    end else if (pick < 186) begin
      r = random_req(REQ_COEF);
      r.ci = 3'($urandom_range(0, 4));
      r.cv = stable_coef(r.ci);
    end else if (pick < 188) begin
      r = random_req(REQ_COEF);
      r.ci = 3'($urandom_range(0, 4));
    end else if (pick < 190) begin
      r = random_req(REQ_COEF);
      r.ci = 3'($urandom_range(5, 7));
    end else if (pick < 196) begin
      r = random_req(REQ_CLEAR);
    end else begin
      r = random_req(REQ_NONE);
    end
    return r;
  endfunction

  task automatic load_stable_coefs();
    for (int s = 0; s < SECTIONS; s++)
      for (int c = 0; c < NCOEF; c++)
        pending_reqs.push_back(coef_req(s, c, stable_coef(3'(c))));
  endtask

  task automatic settle();
    do @(posedge clk_i);
    while (pending_reqs.size() != 0 || src_busy || filtered_q.size() != 0);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic program_sections(input logic [4:0] v);
    cfg_data_i <= v;
    cfg_valid_i <= 1'b1;
    do @(posedge clk_i);
    while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    n_sections = v;
  endtask

  // source side: one transfer per accepted request, gap drawn per item
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (s_axis_tvalid && s_axis_tready) begin
        run_cascade(cur_req);
        src_busy = 1'b0;
      end
      if (!s_axis_tvalid || s_axis_tready) begin
        if (src_wait > 0) begin
          src_wait--;
          s_axis_tvalid <= 1'b0;
        end else if (pending_reqs.size() != 0) begin
          cur_req = pending_reqs.pop_front();
          src_busy = 1'b1;
          s_axis_tvalid <= 1'b1;
          s_axis_tdata <= {1'b0, cur_req.cv, cur_req.ci, cur_req.sec, cur_req.smp};
          s_axis_tuser <= cur_req.kind;
          s_axis_tlast <= cur_req.fe;
          src_wait = draw_wait(src_quiet);
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // sink side: compare each transfer with the oldest prediction
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (m_axis_tvalid && m_axis_tready) begin
        got_out.y = m_axis_tdata;
        got_out.clip = m_axis_tuser[0];
        got_out.fe = m_axis_tlast;
        if (filtered_q.size() == 0) begin
          $display("%0t: unexpected result, actual %0d clip %0b last %0b", $time,
                   got_out.y, got_out.clip, got_out.fe);
          mismatches++;
        end else begin
          want_out = filtered_q.pop_front();
          if (got_out.y !== want_out.y) begin
            $display("%0t: sample_out expected %0d actual %0d", $time, want_out.y, got_out.y);
            mismatches++;
          end
          if (got_out.clip !== want_out.clip) begin
            $display("%0t: clipped expected %0b actual %0b", $time, want_out.clip,
                     got_out.clip);
            mismatches++;
          end
          if (got_out.fe !== want_out.fe) begin
            $display("%0t: frame_end_out expected %0b actual %0b", $time, want_out.fe,
                     got_out.fe);
            mismatches++;
          end
        end
        snk_wait = draw_wait(snk_quiet);
      end
      if (snk_wait > 0) begin
        snk_wait--;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  logic [4:0] set_seq [0:8] = '{5'd16, 5'd1, 5'd31, 5'd4, 5'd0, 5'd9, 5'd17, 5'd2, 5'd16};

  initial begin
    for (int s = 0; s < SECTIONS; s++) begin
      delay_w1[s] = 0;
      delay_w2[s] = 0;
    end
    for (int i = 0; i < SECTIONS * NCOEF; i++) coef_mem[i] = 0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;

    // pass-through at reset, ignored and empty requests
    pending_reqs.push_back(sample_req(32767, 1'b1));
    pending_reqs.push_back(sample_req(-32768, 1'b0));
    pending_reqs.push_back(sample_req(0, 1'b0));
    pending_reqs.push_back(sample_req(-1, 1'b1));
    pending_reqs.push_back(random_req(REQ_NONE));
    pending_reqs.push_back(random_req(REQ_CLEAR));
    pending_reqs.push_back(coef_req(15, 5, -8388608));
    pending_reqs.push_back(coef_req(0, 7, 8388607));
    pending_reqs.push_back(sample_req(1, 1'b0));
    load_stable_coefs();
    settle();

    // count above the section total, then runaway section 0
    program_sections(5'd31);
    pending_reqs.push_back(sample_req(32767, 1'b0));
    pending_reqs.push_back(sample_req(-32768, 1'b1));
    pending_reqs.push_back(coef_req(0, CI_B0, 8388607));
    pending_reqs.push_back(coef_req(0, CI_B1, -8388608));
    pending_reqs.push_back(coef_req(0, CI_B2, 8388607));
    pending_reqs.push_back(coef_req(0, CI_A0, -8388608));
    pending_reqs.push_back(coef_req(0, CI_A1, 8388607));
    for (int i = 0; i < 6; i++)
      pending_reqs.push_back(sample_req((i % 2) ? -32768 : 32767, 1'b0));
    pending_reqs.push_back(random_req(REQ_CLEAR));
    pending_reqs.push_back(sample_req(12345, 1'b1));
    for (int c = 0; c < NCOEF; c++)
      pending_reqs.push_back(coef_req(0, c, stable_coef(3'(c))));

    foreach (set_seq[p]) begin
      settle();
      program_sections(set_seq[p]);
      repeat (RAND_PER_SET) pending_reqs.push_back(random_traffic());
    end
    settle();

    if (mismatches == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
